/* rtl/core/ip_fragment_reorder_buffer_defines.svh */
// Assertion macros shared by the fragment reorder buffer RTL.
// No dependencies; included by the modules that check their own logic.
`ifndef IP_FRAGMENT_REORDER_BUFFER_DEFINES_SVH
`define IP_FRAGMENT_REORDER_BUFFER_DEFINES_SVH
`ifndef ASSERT_OFF
`define FRB_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("frb assertion failed");
`define FRB_ASSERT_RST(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) else $error("frb assertion failed");
`else
`define FRB_ASSERT(lbl, clk, rst_n, prop)
`define FRB_ASSERT_RST(lbl, clk, prop)
`endif
`endif

/* rtl/core/frb_pkg.sv */
// Shared types and constants of the fragment reorder buffer.
// No dependencies.
`timescale 1ns / 1ps
package frb_pkg;
    localparam int MaxFragDef   = 16;
    localparam int HandleBitsDef = 8;
    localparam int InDataBits   = 64;

    typedef enum logic [1:0] {
        ACT_HELD    = 2'd0,
        ACT_RELEASE = 2'd1,
        ACT_DISCARD = 2'd2,
        ACT_REJECT  = 2'd3
    } t_action;

    typedef struct packed {
        logic [15:0] datagram_id;
        logic [12:0] frag_offset;
        logic [15:0] total_length;
        logic [3:0]  header_words;
        logic        more_fragments;
        logic [7:0]  handle;
    } t_frag;
endpackage

/* rtl/core/frb_front.sv */
// Front part: unpacks input words and holds them in a two-entry queue.
// Depends on frb_pkg.
`timescale 1ns / 1ps
`include "ip_fragment_reorder_buffer_defines.svh"
module frb_front (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    input  logic [frb_pkg::InDataBits-1:0]      i_s_tdata,
    output logic                                o_q_valid,
    output frb_pkg::t_frag                      o_q_frag,
    input  logic                                i_q_pop
);
    import frb_pkg::*;

    t_frag       r_mem [2];
    logic        r_wptr, r_rptr;
    logic [1:0]  r_cnt;
    t_frag       w_in;
    logic        w_push, w_pop;

    // unpack the word, lowest field first
    assign w_in.datagram_id    = i_s_tdata[15:0];
    assign w_in.frag_offset    = i_s_tdata[28:16];
    assign w_in.total_length   = i_s_tdata[44:29];
    assign w_in.header_words   = i_s_tdata[48:45];
    assign w_in.more_fragments = i_s_tdata[49];
    assign w_in.handle         = i_s_tdata[57:50];

    assign o_s_tready = (r_cnt != 2'd2);
    assign w_push     = i_s_tvalid && o_s_tready;
    assign o_q_valid  = (r_cnt != 2'd0);
    assign w_pop      = i_q_pop && o_q_valid;
    assign o_q_frag   = r_mem[r_rptr];

    // store pushed word
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wptr] <= w_in;
        end
    end

    // advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            if (w_push) r_wptr <= ~r_wptr;
            if (w_pop)  r_rptr <= ~r_rptr;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end

    `FRB_ASSERT(a_cnt_range, i_clk, i_rst_n, r_cnt != 2'd3)
    `FRB_ASSERT(a_no_push_full, i_clk, i_rst_n, (r_cnt == 2'd2) |-> !w_push)
    `FRB_ASSERT(a_pop_nonempty, i_clk, i_rst_n,
        (w_pop && !w_push && r_cnt == 2'd1) |=> (r_cnt == 2'd0))
endmodule

/* rtl/core/frb_back.sv */
// Back part: ordered fragment store, completeness walk and result register.
// Depends on frb_pkg.
`timescale 1ns / 1ps
`include "ip_fragment_reorder_buffer_defines.svh"
module frb_back #(
    parameter int MAX_FRAGMENTS = frb_pkg::MaxFragDef,
    parameter int HANDLE_BITS   = frb_pkg::HandleBitsDef
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_q_valid,
    input  frb_pkg::t_frag  i_q_frag,
    output logic            o_q_pop,
    output logic            o_m_tvalid,
    input  logic            i_m_tready,
    output logic [7:0]      o_m_tdata,   // out_handle
    output logic [1:0]      o_m_tuser,   // action
    output logic            o_m_tlast    // last
);
    import frb_pkg::*;

    localparam int CW = $clog2(MAX_FRAGMENTS + 1);
    localparam int IW = $clog2(MAX_FRAGMENTS);
    localparam logic [CW-1:0] MaxCnt = CW'(MAX_FRAGMENTS);

    typedef enum logic [5:0] {
        ST_IDLE    = 6'b000001,
        ST_DISCARD = 6'b000010,
        ST_PLACE   = 6'b000100,
        ST_SCAN    = 6'b001000,
        ST_CHECK   = 6'b010000,
        ST_EMIT    = 6'b100000
    } t_state;

    // entry store, kept sorted by offset
    logic [12:0]            r_off [MAX_FRAGMENTS];
    logic [15:0]            r_tl  [MAX_FRAGMENTS];
    logic [3:0]             r_hw  [MAX_FRAGMENTS];
    logic                   r_mf  [MAX_FRAGMENTS];
    logic [HANDLE_BITS-1:0] r_hd  [MAX_FRAGMENTS];

    t_state                 r_state, n_state;
    logic [CW-1:0]          r_count, n_count;
    logic [IW-1:0]          r_idx, n_idx;
    logic [15:0]            r_held_id, n_held_id;
    logic [15:0]            r_end, n_end;
    logic                   r_release, n_release;
    t_frag                  r_cur;
    logic                   r_ovalid, n_ovalid;
    logic [7:0]             r_ohd, n_ohd;
    t_action                r_oact, n_oact;
    logic                   r_olast, n_olast;
    logic                   w_ins;
    logic                   w_free;
    logic                   w_last_idx;
    logic [15:0]            w_start, w_end;
    logic [HANDLE_BITS-1:0] w_new_hd;

    assign w_free     = !r_ovalid || i_m_tready;
    assign w_last_idx = (CW'(r_idx) + CW'(1)) == r_count;
    assign w_start    = {r_off[r_idx], 3'b000};
    assign w_end      = w_start + r_tl[r_idx] - {10'd0, r_hw[r_idx], 2'b00};
    assign w_new_hd   = HANDLE_BITS'(r_cur.handle);

    // sequence one fragment through discard, insert (or reject when full), check and emit
    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_idx     = r_idx;
        n_held_id = r_held_id;
        n_end     = r_end;
        n_release = r_release;
        n_ovalid  = r_ovalid && !i_m_tready;
        n_ohd     = r_ohd;
        n_oact    = r_oact;
        n_olast   = r_olast;
        o_q_pop   = 1'b0;
        w_ins     = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    n_idx   = '0;
                    if (r_count != '0 && i_q_frag.datagram_id != r_held_id) begin
                        n_state = ST_DISCARD;
                    end else begin
                        n_state = ST_PLACE;
                    end
                end
            end
            ST_DISCARD: begin
                if (w_free) begin
                    n_ovalid = 1'b1;
                    n_oact   = ACT_DISCARD;
                    n_ohd    = 8'(r_hd[r_idx]);
                    n_olast  = 1'b0;
                    n_idx    = r_idx + IW'(1);
                    if (w_last_idx) begin
                        n_count = '0;
                        n_idx   = '0;
                        n_state = ST_PLACE;
                    end
                end
            end
            ST_PLACE: begin
                if (r_count == MaxCnt) begin
                    if (w_free) begin
                        n_ovalid = 1'b1;
                        n_oact   = ACT_REJECT;
                        n_ohd    = 8'(w_new_hd);
                        n_olast  = 1'b1;
                        n_state  = ST_IDLE;
                    end
                end else begin
                    if (r_count == '0) n_held_id = r_cur.datagram_id;
                    n_idx   = '0;
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                // walk past entries whose offset is not above the new one
                if (CW'(r_idx) < r_count && r_off[r_idx] <= r_cur.frag_offset) begin
                    n_idx = r_idx + IW'(1);
                end else begin
                    w_ins   = 1'b1;
                    n_count = r_count + CW'(1);
                    n_idx   = '0;
                    n_end   = '0;
                    n_state = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (w_start != r_end) begin
                    n_release = 1'b0;
                    n_state   = ST_EMIT;
                end else if (w_last_idx) begin
                    n_release = !r_mf[r_idx];
                    n_idx     = '0;
                    n_state   = ST_EMIT;
                end else begin
                    n_end = w_end;
                    n_idx = r_idx + IW'(1);
                end
            end
            ST_EMIT: begin
                if (w_free) begin
                    n_ovalid = 1'b1;
                    if (r_release) begin
                        n_oact  = ACT_RELEASE;
                        n_ohd   = 8'(r_hd[r_idx]);
                        n_olast = w_last_idx;
                        n_idx   = r_idx + IW'(1);
                        if (w_last_idx) begin
                            n_count = '0;
                            n_state = ST_IDLE;
                        end
                    end else begin
                        n_oact  = ACT_HELD;
                        n_ohd   = 8'(w_new_hd);
                        n_olast = 1'b1;
                        n_state = ST_IDLE;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_count   <= '0;
            r_held_id <= '0;
            r_ovalid  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_held_id <= n_held_id;
            r_ovalid  <= n_ovalid;
        end
    end

    // working and result payload
    always_ff @(posedge i_clk) begin
        r_idx     <= n_idx;
        r_end     <= n_end;
        r_release <= n_release;
        r_ohd     <= n_ohd;
        r_oact    <= n_oact;
        r_olast   <= n_olast;
        if (o_q_pop) r_cur <= i_q_frag;
    end

    // shift entries above the slot up by one and drop the new one in
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < MAX_FRAGMENTS; i++) begin
            if (w_ins) begin
                if (IW'(i) == r_idx) begin
                    r_off[i] <= r_cur.frag_offset;
                    r_tl[i]  <= r_cur.total_length;
                    r_hw[i]  <= r_cur.header_words;
                    r_mf[i]  <= r_cur.more_fragments;
                    r_hd[i]  <= w_new_hd;
                end else if (i > 0 && IW'(i) > r_idx) begin
                    r_off[i] <= r_off[(i > 0) ? i - 1 : 0];
                    r_tl[i]  <= r_tl[(i > 0) ? i - 1 : 0];
                    r_hw[i]  <= r_hw[(i > 0) ? i - 1 : 0];
                    r_mf[i]  <= r_mf[(i > 0) ? i - 1 : 0];
                    r_hd[i]  <= r_hd[(i > 0) ? i - 1 : 0];
                end
            end
        end
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = r_ohd;
    assign o_m_tuser  = r_oact;
    assign o_m_tlast  = r_olast;

    `FRB_ASSERT(a_count_max, i_clk, i_rst_n, r_count <= MaxCnt)
    `FRB_ASSERT(a_discard_nonempty, i_clk, i_rst_n,
        (r_state == ST_DISCARD) |-> (r_count != '0))
    `FRB_ASSERT(a_release_empties, i_clk, i_rst_n,
        (r_state == ST_EMIT && w_free && r_release && w_last_idx) |=> (r_count == '0))
    `FRB_ASSERT(a_insert_room, i_clk, i_rst_n, w_ins |-> (r_count < MaxCnt))
endmodule

/* rtl/core/ip_fragment_reorder_buffer.sv */
// IPv4 fragment reorder buffer, top level.
// Channels: slave stream takes one fragment descriptor per word; tdata holds
// datagram_id, frag_offset, total_length, header_words, more_fragments and
// handle from bit 0 up. Master stream gives one result per word: tdata is
// the handle, tuser the action (held, release, discard, reject) and tlast
// marks the final result caused by one descriptor.
// A two-entry queue parts the input from the sequencer, and a result
// register parts the sequencer from the output, so either side may stall.
// Per descriptor the sequencer dequeues it, discards each held entry of
// another datagram, places or rejects it, scans to its slot, checks the
// run of offsets and then emits its results (every entry on a release).
// It walks the store one entry per cycle, but waits at each result while
// the result register is full.
// Reset empties the store and queue at once; no clearing pass is needed.
// While the receiver holds tready low the sequencer waits at its next result.
// Depends on frb_pkg, frb_front and frb_back.
`timescale 1ns / 1ps
module ip_fragment_reorder_buffer #(
    parameter int MAX_FRAGMENTS = frb_pkg::MaxFragDef,
    parameter int HANDLE_BITS   = frb_pkg::HandleBitsDef
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    // datagram_id, frag_offset, total_length, header_words, more_fragments, handle
    input  logic [frb_pkg::InDataBits-1:0]  i_s_tdata,
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    output logic [7:0]                      o_m_tdata,   // out_handle
    output logic [1:0]                      o_m_tuser,   // action
    output logic                            o_m_tlast    // last
);
    import frb_pkg::*;

    logic  w_q_valid, w_q_pop;
    t_frag w_q_frag;

    frb_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_q_valid  (w_q_valid),
        .o_q_frag   (w_q_frag),
        .i_q_pop    (w_q_pop)
    );

    frb_back #(
        .MAX_FRAGMENTS (MAX_FRAGMENTS),
        .HANDLE_BITS   (HANDLE_BITS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (w_q_valid),
        .i_q_frag   (w_q_frag),
        .o_q_pop    (w_q_pop),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );
endmodule

/* tb/tb_top.sv */
// Testbench for the IPv4 fragment reorder buffer: drives fragment descriptors,
// predicts held/release/discard/reject words and checks each output word.
// Depends on frb_pkg and ip_fragment_reorder_buffer.
`timescale 1ns / 1ps
module tb_top;
    import frb_pkg::*;

    localparam int NumFrag = 16;

    typedef struct {
        t_action     act;
        logic [7:0]  hnd;
        logic        lst;
    } t_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [63:0] i_s_tdata = '0;
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [7:0]  o_m_tdata;
    logic [1:0]  o_m_tuser;
    logic        o_m_tlast;

    // Predictor state: fragments held in offset order
    logic [15:0] pred_id = '0;
    int          pred_count = 0;
    t_frag       pred_store [NumFrag];
    t_result     expected_words [$];

    int  errors = 0;
    int  cycles = 0;
    int  rx_wait = 0;
    bit  long_stall = 1'b0;

    ip_fragment_reorder_buffer dut (.*);

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Bound the run
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 2000000) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic void push_word(t_action a, logic [7:0] h);
        t_result r;
        r.act = a;
        r.hnd = h;
        r.lst = 1'b0;
        expected_words.push_back(r);
    endfunction

    function automatic bit set_is_complete();
        logic [15:0] run_end;
        logic [15:0] start;
        run_end = '0;
        for (int i = 0; i < pred_count; i++) begin
            start = {pred_store[i].frag_offset, 3'b000};
            if (start != run_end) return 1'b0;
            run_end = start + pred_store[i].total_length
                      - {10'd0, pred_store[i].header_words, 2'b00};
        end
        return pred_count > 0 && !pred_store[pred_count-1].more_fragments;
    endfunction

    // Predict the words caused by one accepted descriptor
    function automatic void predict_fragment(t_frag f);
        int pos;
        if (pred_count > 0 && f.datagram_id != pred_id) begin
            for (int i = 0; i < pred_count; i++) push_word(ACT_DISCARD, pred_store[i].handle);
            pred_count = 0;
        end
        if (pred_count >= NumFrag) begin
            push_word(ACT_REJECT, f.handle);
        end else begin
            if (pred_count == 0) pred_id = f.datagram_id;
            pos = 0;
            while (pos < pred_count && pred_store[pos].frag_offset <= f.frag_offset) pos++;
            for (int i = pred_count; i > pos; i--) pred_store[i] = pred_store[i-1];
            pred_store[pos] = f;
            pred_count++;
            if (set_is_complete()) begin
                for (int i = 0; i < pred_count; i++) push_word(ACT_RELEASE, pred_store[i].handle);
                pred_count = 0;
            end else begin
                push_word(ACT_HELD, f.handle);
            end
        end
        expected_words[$].lst = 1'b1;
    endfunction

    // Send one descriptor after a random gap; valid stays up across a zero gap
    task automatic send_fragment(t_frag f);
        int gap;
        gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 19);
        if (gap != 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata <= {6'd0, f.handle, f.more_fragments, f.header_words,
                      f.total_length, f.frag_offset, f.datagram_id};
        do @(posedge i_clk); while (!o_s_tready);
        predict_fragment(f);
    endtask

    function automatic t_frag make_frag(logic [15:0] id, logic [12:0] off, logic [15:0] tl,
                                        logic [3:0] hw, logic mf, logic [7:0] h);
        t_frag f;
        f.datagram_id = id;
        f.frag_offset = off;
        f.total_length = tl;
        f.header_words = hw;
        f.more_fragments = mf;
        f.handle = h;
        return f;
    endfunction

    // Receiver: random wait before each word, or a long hold-off on request
    always @(posedge i_clk) begin
        int rx_draw;
        if (!i_rst_n || long_stall) begin
            i_m_tready <= 1'b0;
        end else if (o_m_tvalid && i_m_tready) begin
            rx_draw = $urandom_range(0, 19);
            rx_wait <= rx_draw;
            i_m_tready <= (rx_draw == 0);
        end else if (rx_wait > 1) begin
            rx_wait <= rx_wait - 1;
        end else begin
            rx_wait <= 0;
            i_m_tready <= 1'b1;
        end
    end

    // Check each accepted output word
    always @(posedge i_clk) begin
        t_result e;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (expected_words.size() == 0) begin
                $error("unexpected word handle=%0h action=%0d", o_m_tdata, o_m_tuser);
                errors++;
            end else begin
                e = expected_words.pop_front();
                if (o_m_tuser != e.act) begin
                    $error("action: expected %0d got %0d", e.act, o_m_tuser);
                    errors++;
                end
                if (o_m_tdata != e.hnd) begin
                    $error("out_handle: expected %0h got %0h", e.hnd, o_m_tdata);
                    errors++;
                end
                if (o_m_tlast != e.lst) begin
                    $error("last: expected %0d got %0d", e.lst, o_m_tlast);
                    errors++;
                end
            end
        end
    end

    // Send a whole datagram of n fragments in shuffled order, optionally dropping one
    task automatic send_datagram(logic [15:0] id, int n, bit drop_one);
        t_frag frags [$];
        int    skip;
        logic [15:0] off_bytes;
        logic [15:0] pay;
        logic [3:0]  hw;
        off_bytes = '0;
        for (int i = 0; i < n; i++) begin
            hw = 4'($urandom_range(5, 15));
            pay = 16'(8 * $urandom_range(1, 40));
            frags.push_back(make_frag(id, off_bytes[15:3], pay + {10'd0, hw, 2'b00}, hw,
                                      i != n - 1, 8'($urandom)));
            off_bytes += pay;
        end
        frags.shuffle();
        skip = drop_one ? $urandom_range(0, n - 1) : -1;
        foreach (frags[i]) if (i != skip) send_fragment(frags[i]);
    endtask

    task automatic test_directed();
        send_fragment(make_frag(16'h0000, 13'd0, 16'd20, 4'd5, 1'b0, 8'h00));
        send_fragment(make_frag(16'hFFFF, 13'h1FFF, 16'hFFFF, 4'd15, 1'b1, 8'hFF));
        send_fragment(make_frag(16'h1234, 13'd0, 16'd0, 4'd0, 1'b1, 8'hA5));
        send_fragment(make_frag(16'h1234, 13'd0, 16'd28, 4'd5, 1'b1, 8'h5A));
        send_fragment(make_frag(16'h1234, 13'd1, 16'd40, 4'd8, 1'b0, 8'h3C));
        // Equal offsets whose ends wrap the 16-bit range, then a two-fragment datagram
        send_fragment(make_frag(16'h0042, 13'h1FFF, 16'h0010, 4'd2, 1'b1, 8'h11));
        send_fragment(make_frag(16'h0042, 13'h1FFF, 16'h0020, 4'd3, 1'b0, 8'h22));
        send_fragment(make_frag(16'h0043, 13'd0, 16'hFFFF, 4'd15, 1'b1, 8'h33));
        send_fragment(make_frag(16'h0043, 13'h1FF5, 16'h006C, 4'd15, 1'b0, 8'h44));
        send_datagram(16'h0777, 3, 1'b0);
    endtask

    // Fill the store to overflow while the receiver holds off
    task automatic test_full_store();
        // Hold the receiver off for a counted stretch in its own process
        fork
            begin
                long_stall = 1'b1;
                repeat (400) @(posedge i_clk);
                long_stall = 1'b0;
            end
        join_none
        for (int i = 0; i < NumFrag + 3; i++)
            send_fragment(make_frag(16'hBEEF, 13'(i + 1), 16'd40, 4'd5, 1'b1, 8'(i)));
    endtask

    // Mostly well-formed datagrams, with broken sets and random noise
    task automatic test_random();
        t_frag f;
        int    sent;
        int    n;
        sent = 0;
        while (sent < 460) begin
            n = $urandom_range(1, 10) == 1 ? $urandom_range(12, 17) : $urandom_range(1, 6);
            case ($urandom_range(0, 9))
                0, 1: begin
                    f = make_frag(16'($urandom), 13'($urandom), 16'($urandom),
                                  4'($urandom), 1'($urandom), 8'($urandom));
                    send_fragment(f);
                    n = 1;
                end
                2: send_datagram(16'($urandom), n, 1'b1);
                default: send_datagram($urandom_range(0, 3) == 0 ? 16'h0 : 16'($urandom),
                                       n, 1'b0);
            endcase
            sent += n;
        end
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_full_store();
        test_random();
        i_s_tvalid <= 1'b0;
        while (expected_words.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        if (errors == 0 && expected_words.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule
